/* sv/sorted_wakeup_timer_queue_unit_macros.svh */
// Assertion macros used by the timer queue RTL.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SWTQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swtq assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SWTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swtq assertion failed");
`else
`define SWTQ_ASSERT_NOW(label, ante, cons)
`define SWTQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/swtq_pkg.sv */
`default_nettype none
package swtq_pkg;

	localparam int TICK_W = 63;
	localparam int ID_W = 8;
	localparam int DUR_W = 32;
	localparam int KIND_W = 2;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		EV_WOKEN   = 2'd0,
		EV_REFUSED = 2'd1,
		EV_FULL    = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [TICK_W-1:0] wake;
		logic [ID_W-1:0]   id;
	} entry_t;

	localparam int ENTRY_W = TICK_W + ID_W;

endpackage
`default_nettype wire

/* sv/sorted_wakeup_timer_queue_unit.sv */
// Sleep request: a refusal is answered from ST_SLEEP; an insert moves each queued entry
//   with a later wake time up one slot in the queue RAM.
// Tick: one RAM read per waiter released (at most 16).
// A new request is taken only when the previous one is finished; results wait
//   in an output register. Reset (arst_n low) empties the queue and zeroes the
//   counter at once; queue RAM contents are not cleared.
`default_nettype none
`include "sorted_wakeup_timer_queue_unit_macros.svh"
module sorted_wakeup_timer_queue_unit
	import swtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    command,
	input  wire logic [ID_W-1:0]         waiter_id,
	input  wire logic signed [DUR_W-1:0] sleep_ticks,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic      [KIND_W-1:0]       event_kind,
	output logic      [ID_W-1:0]         result_waiter,
	output logic      [TICK_W-1:0]       tick_now,
	output logic                         last_result
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLEEP,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_WAKE_RD,
		ST_WAKE_CHK
	} state_t;

	state_t                   state_q;
	logic [TICK_W-1:0]        tick_q;
	logic [OW-1:0]            occ_q;
	logic [PW-1:0]            head_q;
	logic [PW-1:0]            k_q;
	logic [NW-1:0]            n_q;
	logic [ID_W-1:0]          id_q;
	logic signed [DUR_W-1:0]  dur_q;
	logic [TICK_W-1:0]        when_q;
	logic                     pend_vld_q;
	logic [ID_W-1:0]          pend_id_q;
	logic                     out_valid_q;
	event_kind_t              kind_q;
	logic [ID_W-1:0]          res_id_q;
	logic [TICK_W-1:0]        res_tick_q;
	logic                     last_q;

	logic                     ram_we;
	logic [PW-1:0]            ram_waddr;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic [PW-1:0]            ram_raddr;
	logic [ENTRY_W-1:0]       ram_rdata;
	entry_t                   rd_ent;
	entry_t                   new_ent;

	logic                     out_free;
	logic                     nonpos;
	logic                     full;
	logic [TICK_W:0]          when_sum;
	logic [TICK_W-1:0]        when_sat;
	logic                     due;
	logic                     can_go;
	logic [PW-1:0]            head_nxt;

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
			input logic [PW-1:0] off);
		logic [PW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (PW+1)'(QUEUE_DEPTH)) begin
			s = s - (PW+1)'(QUEUE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	swtq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_ent   = entry_t'(ram_rdata);
	assign new_ent  = '{wake: when_q, id: id_q};
	assign out_free = !out_valid_q || out_ready;
	assign nonpos   = (dur_q == '0) || dur_q[DUR_W-1];
	assign full     = occ_q >= OW'(QUEUE_DEPTH);
	assign when_sum = {1'b0, tick_q} + (TICK_W+1)'(unsigned'(dur_q));
	assign when_sat = when_sum[TICK_W] ? TICK_MAX : when_sum[TICK_W-1:0];
	assign due      = (occ_q != '0) && (n_q < NW'(MAX_RESULTS)) && (rd_ent.wake <= tick_q);
	assign can_go   = !pend_vld_q || out_free;
	assign head_nxt = phys(head_q, PW'(1));

	always_comb begin
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, k_q);
		ram_wdata = new_ent;
		case (state_q)
			ST_SLEEP: begin
				ram_raddr = phys(head_q, occ_q[PW-1:0] - PW'(1));
			end
			ST_INS_CMP: begin
				ram_raddr = phys(head_q, k_q - PW'(2));
				ram_we    = 1'b1;
				if (rd_ent.wake > when_q) begin
					ram_wdata = ram_rdata;
				end
			end
			ST_INS_PUT: begin
				ram_we = 1'b1;
			end
			ST_WAKE_CHK: begin
				if (can_go && due) begin
					ram_raddr = head_nxt;
				end
			end
			default: begin
				ram_raddr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			occ_q       <= '0;
			head_q      <= '0;
			k_q         <= '0;
			n_q         <= '0;
			id_q        <= '0;
			dur_q       <= '0;
			when_q      <= '0;
			pend_vld_q  <= 1'b0;
			pend_id_q   <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= EV_WOKEN;
			res_id_q    <= '0;
			res_tick_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						id_q  <= waiter_id;
						dur_q <= sleep_ticks;
						if (command == CMD_SLEEP) begin
							state_q <= ST_SLEEP;
						end else begin
							if (tick_q != TICK_MAX) begin
								tick_q <= tick_q + TICK_W'(1);
							end
							n_q     <= '0;
							state_q <= ST_WAKE_RD;
						end
					end
				end
				ST_SLEEP: begin
					if (nonpos || full) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							kind_q      <= nonpos ? EV_REFUSED : EV_FULL;
							res_id_q    <= id_q;
							res_tick_q  <= tick_q;
							last_q      <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						when_q  <= when_sat;
						k_q     <= occ_q[PW-1:0];
						state_q <= (occ_q == '0) ? ST_INS_PUT : ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (rd_ent.wake > when_q) begin
						k_q <= k_q - PW'(1);
						if (k_q == PW'(1)) begin
							state_q <= ST_INS_PUT;
						end
					end else begin
						occ_q   <= occ_q + OW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_INS_PUT: begin
					occ_q   <= occ_q + OW'(1);
					state_q <= ST_IDLE;
				end
				ST_WAKE_RD: begin
					state_q <= ST_WAKE_CHK;
				end
				ST_WAKE_CHK: begin
					if (can_go) begin
						if (pend_vld_q) begin
							out_valid_q <= 1'b1;
							kind_q      <= EV_WOKEN;
							res_id_q    <= pend_id_q;
							res_tick_q  <= tick_q;
							last_q      <= !due;
						end
						if (due) begin
							pend_id_q  <= rd_ent.id;
							pend_vld_q <= 1'b1;
							head_q     <= head_nxt;
							occ_q      <= occ_q - OW'(1);
							n_q        <= n_q + NW'(1);
						end else begin
							pend_vld_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign result_waiter = res_id_q;
	assign tick_now      = res_tick_q;
	assign last_result   = last_q;

	`SWTQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OW'(QUEUE_DEPTH))
	`SWTQ_ASSERT_NOW(a_idle_no_pend, state_q == ST_IDLE, !pend_vld_q)
	`SWTQ_ASSERT_NOW(a_burst_bound, 1'b1, n_q <= NW'(MAX_RESULTS))
	`SWTQ_ASSERT_NOW(a_ins_slot, state_q == ST_INS_CMP, k_q != '0)
	`SWTQ_ASSERT_NEXT(a_tick_mono, 1'b1, tick_q >= $past(tick_q))

endmodule
`default_nettype wire

/* sv/swtq_ram.sv */
`default_nettype none
module swtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* test/swtq_checker.sv */
`timescale 1ns / 100ps
module swtq_checker
	import swtq_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_ready,
	input  wire logic                    command,
	input  wire logic [ID_W-1:0]         waiter_id,
	input  wire logic signed [DUR_W-1:0] sleep_ticks,
	input  wire logic                    out_valid,
	input  wire logic                    out_ready,
	input  wire logic [KIND_W-1:0]       event_kind,
	input  wire logic [ID_W-1:0]         result_waiter,
	input  wire logic [TICK_W-1:0]       tick_now,
	input  wire logic                    last_result,
	output int                           fail_total,
	output int                           outstanding
);

	typedef struct packed {
		event_kind_t       kind;
		logic [ID_W-1:0]   waiter;
		logic [TICK_W-1:0] now;
		logic              closing;
	} wake_event_t;

	wake_event_t       due_events[$];
	logic [TICK_W-1:0] tick_cnt;
	logic [TICK_W-1:0] wake_q[DEPTH];
	logic [ID_W-1:0]   id_q[DEPTH];
	int                occ;
	int                err_cnt = 0;
	int                wait_cnt = 0;

	assign fail_total = err_cnt;
	assign outstanding = wait_cnt;

	function automatic void note_event(input event_kind_t kind, input logic [ID_W-1:0] id,
			input logic [TICK_W-1:0] now, input logic closing);
		wake_event_t ev;
		ev.kind = kind;
		ev.waiter = id;
		ev.now = now;
		ev.closing = closing;
		due_events.push_back(ev);
	endfunction

	task automatic predict_request(input logic cmd, input logic [ID_W-1:0] id,
			input logic signed [DUR_W-1:0] dur);
		logic [TICK_W-1:0] span;
		logic [TICK_W-1:0] due;
		logic              closing;
		int                pos;
		int                i;
		int                n;
		if (cmd == CMD_SLEEP) begin
			if (dur <= 0)
				note_event(EV_REFUSED, id, tick_cnt, 1'b1);
			else if (occ >= DEPTH)
				note_event(EV_FULL, id, tick_cnt, 1'b1);
			else begin
				span = {{(TICK_W-DUR_W){1'b0}}, dur};
				// wake time saturates at the counter maximum
				if (tick_cnt > TICK_MAX - span)
					due = TICK_MAX;
				else
					due = tick_cnt + span;
				pos = 0;
				while (pos < occ && wake_q[pos] <= due)
					pos++;
				for (i = occ; i > pos; i--) begin
					wake_q[i] = wake_q[i-1];
					id_q[i] = id_q[i-1];
				end
				wake_q[pos] = due;
				id_q[pos] = id;
				occ++;
			end
		end else begin
			if (tick_cnt != TICK_MAX)
				tick_cnt = tick_cnt + 1'b1;
			n = 0;
			while (n < MAX_RESULTS && occ > 0 && wake_q[0] <= tick_cnt) begin
				closing = !(n + 1 < MAX_RESULTS && occ > 1 && wake_q[1] <= tick_cnt);
				note_event(EV_WOKEN, id_q[0], tick_cnt, closing);
				for (i = 1; i < occ; i++) begin
					wake_q[i-1] = wake_q[i];
					id_q[i-1] = id_q[i];
				end
				occ--;
				n++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		wake_event_t exp;
		if (!arst_n) begin
			tick_cnt = '0;
			occ = 0;
			due_events.delete();
			wait_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_events.size() == 0) begin
					$error("unexpected result: kind %0d waiter %0d tick %0d",
						event_kind, result_waiter, tick_now);
					err_cnt++;
				end else begin
					exp = due_events.pop_front();
					if (event_kind !== exp.kind) begin
						$error("event_kind: expected %0d, got %0d", exp.kind, event_kind);
						err_cnt++;
					end
					if (result_waiter !== exp.waiter) begin
						$error("result_waiter: expected %0d, got %0d", exp.waiter,
							result_waiter);
						err_cnt++;
					end
					if (tick_now !== exp.now) begin
						$error("tick_now: expected %0d, got %0d", exp.now, tick_now);
						err_cnt++;
					end
					if (last_result !== exp.closing) begin
						$error("last_result: expected %0d, got %0d", exp.closing,
							last_result);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_request(command, waiter_id, sleep_ticks);
			wait_cnt = due_events.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
module tb_top
	import swtq_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 152;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    command = CMD_TICK;
	logic [ID_W-1:0]         waiter_id = '0;
	logic signed [DUR_W-1:0] sleep_ticks = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [KIND_W-1:0]       event_kind;
	logic [ID_W-1:0]         result_waiter;
	logic [TICK_W-1:0]       tick_now;
	logic                    last_result;

	int fail_total;
	int outstanding;
	int tx_idle_pct = 20;
	int rx_stall_pct = 55;
	int quiet_cycles = 0;
	int n_ticks = 0;
	int n_sleeps = 0;
	int n_results = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_wakeup_timer_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.waiter_id(waiter_id),
		.sleep_ticks(sleep_ticks),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.result_waiter(result_waiter),
		.tick_now(tick_now),
		.last_result(last_result)
	);

	swtq_checker #(
		.DEPTH(QUEUE_DEPTH_DEF)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.waiter_id(waiter_id),
		.sleep_ticks(sleep_ticks),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.result_waiter(result_waiter),
		.tick_now(tick_now),
		.last_result(last_result),
		.fail_total(fail_total),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			n_results <= n_results + 1;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
			input logic signed [DUR_W-1:0] dur);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		waiter_id <= id;
		sleep_ticks <= dur;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (cmd == CMD_SLEEP)
			n_sleeps++;
		else
			n_ticks++;
	endtask

	task automatic send_tick();
		send_request(CMD_TICK, ID_W'($urandom), $urandom);
	endtask

	task automatic send_random_mix(input int count);
		int                      pick;
		logic signed [DUR_W-1:0] span;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_tick();
			else begin
				if (pick < 44)
					span = '0;
				else if (pick < 48)
					span = {1'b1, 31'($urandom)};
				else if (pick < 52)
					span = $urandom_range(1, 200);
				else
					span = $urandom_range(1, 16);
				send_request(CMD_SLEEP, ID_W'($urandom), span);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nonpositive durations
		send_request(CMD_SLEEP, 8'h00, 32'sd0);
		send_request(CMD_SLEEP, 8'hFF, -32'sd1);
		send_request(CMD_SLEEP, 8'h5A, 32'sh8000_0000);
		send_tick();
		// fill the queue with equal wake times, overflow it, then wake all at once
		for (int k = 0; k < QUEUE_DEPTH_DEF; k++)
			send_request(CMD_SLEEP, ID_W'(k * 17), 32'sd3);
		send_request(CMD_SLEEP, 8'hA5, 32'sd1);
		repeat (3) send_tick();
		send_request(CMD_SLEEP, 8'h3C, 32'sh7FFF_FFFF);
		send_tick();

		send_random_mix(PHASE_ITEMS);
		tx_idle_pct = 55;
		rx_stall_pct = 20;
		send_random_mix(PHASE_ITEMS);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_random_mix(PHASE_ITEMS);
		in_valid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d ticks and %0d sleep requests accepted, %0d results checked",
			n_ticks, n_sleeps, n_results);
		$display("run: covered refusals, full queue, tied wake times and full wake bursts");
		if (fail_total == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/swtq_pkg.sv
sv/swtq_ram.sv
sv/sorted_wakeup_timer_queue_unit.sv
test/swtq_checker.sv
test/tb_top.sv
